// ===== hdl/ste_pkg.sv =====
package ste_pkg;

  // operation codes carried in the func field
  typedef enum logic [3:0] {
    OP_READ       = 4'd0,
    OP_WRITE      = 4'd1,
    OP_CLEAR      = 4'd2,
    OP_REMOVE     = 4'd3,
    OP_PUT        = 4'd4,
    OP_POP        = 4'd5,
    OP_COUNT      = 4'd6,
    OP_ITER_RESET = 4'd7,
    OP_ITER_NEXT  = 4'd8
  } op_e;

  // cells searched between two chain registers
  localparam int SegCells = 8;

  // configuration port
  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_SLOTS_IN_USE = 1'b0;
  localparam logic [7:0] SLOTS_IN_USE_RESET = 8'd128;

endpackage

// ===== hdl/ste_req_if.sv =====
interface ste_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  func;
  logic [6:0]  slot_index;
  logic [31:0] handle;

  modport source (output valid, output func, output slot_index, output handle, input ready);
  modport sink (input valid, input func, input slot_index, input handle, output ready);
endinterface

// ===== hdl/ste_rsp_if.sv =====
interface ste_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_handle;
  logic [6:0]  result_index;
  logic        hit;
  logic [7:0]  item_count;

  modport source (output valid, output result_handle, output result_index, output hit,
                  output item_count, input ready);
  modport sink (input valid, input result_handle, input result_index, input hit,
                input item_count, output ready);
endinterface

// ===== hdl/ste_cell.sv =====
module ste_cell #(
  parameter int CELL_INDEX  = 0,
  parameter int SLOTS       = 128,
  parameter int HANDLE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       wave_i,
  input  logic [3:0]                 func_i,
  input  logic [6:0]                 slot_index_i,
  input  logic [HANDLE_BITS-1:0]     handle_i,
  input  logic [$clog2(SLOTS+1)-1:0] size_i,
  input  logic [$clog2(SLOTS+1)-1:0] iter_pos_i,
  input  logic                       found_i,
  input  logic [HANDLE_BITS-1:0]     found_handle_i,
  input  logic [$clog2(SLOTS)-1:0]   found_index_i,
  output logic                       found_o,
  output logic [HANDLE_BITS-1:0]     found_handle_o,
  output logic [$clog2(SLOTS)-1:0]   found_index_o
);
  import ste_pkg::*;

  localparam int CntW = $clog2(SLOTS + 1);
  localparam int IdxW = $clog2(SLOTS);

  logic                   valid_q, valid_d;
  logic [HANDLE_BITS-1:0] data_q, data_d;
  logic [HANDLE_BITS-1:0] slot_val;
  logic                   in_range, idx_eq, iter_ge, h_nz, match, claim;

  assign slot_val = valid_q ? data_q : '0;
  assign in_range = CntW'(CELL_INDEX) < size_i;
  assign idx_eq   = {25'd0, slot_index_i} == 32'(CELL_INDEX);
  assign iter_ge  = iter_pos_i <= CntW'(CELL_INDEX);
  assign h_nz     = |handle_i;

  always_comb begin
    case (func_i)
      OP_READ, OP_WRITE, OP_CLEAR: match = idx_eq;
      OP_REMOVE:    match = h_nz & valid_q & (data_q == handle_i);
      OP_PUT:       match = h_nz & ~valid_q;
      OP_POP:       match = valid_q;
      OP_ITER_NEXT: match = valid_q & iter_ge;
      default:      match = 1'b0;
    endcase
  end

  // first matching cell in range takes the request
  assign claim          = wave_i & in_range & match & ~found_i;
  assign found_o        = found_i | claim;
  assign found_handle_o = claim ? slot_val : found_handle_i;
  assign found_index_o  = claim ? IdxW'(CELL_INDEX) : found_index_i;

  always_comb begin
    valid_d = valid_q;
    data_d  = data_q;
    if (claim) begin
      case (func_i)
        OP_WRITE: begin
          valid_d = h_nz;
          data_d  = handle_i;
        end
        OP_PUT: begin
          valid_d = 1'b1;
          data_d  = handle_i;
        end
        OP_CLEAR, OP_REMOVE, OP_POP: valid_d = 1'b0;
        default: valid_d = valid_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// ===== hdl/ste_chain.sv =====
module ste_chain #(
  parameter int SLOTS       = 128,
  parameter int HANDLE_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [3:0]                 func_i,
  input  logic [6:0]                 slot_index_i,
  input  logic [HANDLE_BITS-1:0]     handle_i,
  input  logic [$clog2(SLOTS+1)-1:0] size_i,
  input  logic [$clog2(SLOTS+1)-1:0] iter_pos_i,
  output logic                       res_valid_o,
  output logic                       res_found_o,
  output logic [HANDLE_BITS-1:0]     res_handle_o,
  output logic [$clog2(SLOTS)-1:0]   res_index_o
);
  import ste_pkg::*;

  localparam int IdxW = $clog2(SLOTS);
  localparam int NSeg = (SLOTS + SegCells - 1) / SegCells;

  // wave of the request leaving each segment, with its search result so far
  logic [NSeg-1:0]        act;
  logic [NSeg-1:0]        act_q;
  logic                   lf_q [NSeg];
  logic [HANDLE_BITS-1:0] lh_q [NSeg];
  logic [IdxW-1:0]        li_q [NSeg];

  logic                   f_in  [SLOTS];
  logic [HANDLE_BITS-1:0] h_in  [SLOTS];
  logic [IdxW-1:0]        i_in  [SLOTS];
  logic                   f_out [SLOTS];
  logic [HANDLE_BITS-1:0] h_out [SLOTS];
  logic [IdxW-1:0]        i_out [SLOTS];

  for (genvar c = 0; c < SLOTS; c++) begin : g_cell
    if (c == 0) begin : g_head
      assign f_in[c] = 1'b0;
      assign h_in[c] = '0;
      assign i_in[c] = '0;
    end else if (c % SegCells == 0) begin : g_seg_head
      assign f_in[c] = lf_q[c / SegCells - 1];
      assign h_in[c] = lh_q[c / SegCells - 1];
      assign i_in[c] = li_q[c / SegCells - 1];
    end else begin : g_link
      assign f_in[c] = f_out[c-1];
      assign h_in[c] = h_out[c-1];
      assign i_in[c] = i_out[c-1];
    end

    ste_cell #(
      .CELL_INDEX (c),
      .SLOTS      (SLOTS),
      .HANDLE_BITS(HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .wave_i        (act[c / SegCells]),
      .func_i        (func_i),
      .slot_index_i  (slot_index_i),
      .handle_i      (handle_i),
      .size_i        (size_i),
      .iter_pos_i    (iter_pos_i),
      .found_i       (f_in[c]),
      .found_handle_i(h_in[c]),
      .found_index_i (i_in[c]),
      .found_o       (f_out[c]),
      .found_handle_o(h_out[c]),
      .found_index_o (i_out[c])
    );
  end

  for (genvar s = 0; s < NSeg; s++) begin : g_seg
    localparam int Last = ((s + 1) * SegCells < SLOTS) ? (s + 1) * SegCells - 1 : SLOTS - 1;

    if (s == 0) begin : g_first
      assign act[s] = start_i;
    end else begin : g_next
      assign act[s] = act_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        act_q[s] <= 1'b0;
      end else begin
        act_q[s] <= act[s];
      end
    end

    always_ff @(posedge clk_i) begin
      lf_q[s] <= f_out[Last];
      lh_q[s] <= h_out[Last];
      li_q[s] <= i_out[Last];
    end
  end

  assign res_valid_o  = act_q[NSeg-1];
  assign res_found_o  = lf_q[NSeg-1];
  assign res_handle_o = lh_q[NSeg-1];
  assign res_index_o  = li_q[NSeg-1];

endmodule

// ===== hdl/slot_table_engine_top.sv =====
// slot table engine: a table of SLOTS handles, 0 meaning an empty slot
//
// req_i carries one request (func, slot_index, handle) with a valid/ready
// handshake; rsp_o returns exactly one result per request (result_handle,
// result_index, hit, item_count) in request order.
// the APB port holds slots_in_use at address 0; write it only while idle.
//
// each slot lives in its own cell. a request runs as a wave down the row of
// cells, eight cells per cycle, with a register between groups of eight;
// the first matching cell in range claims it, updates itself and hands the
// old handle and its index down the chain.
// one request is in flight at a time: no new request is taken until the wave
// through the cell row has finished and its result has left for the output stage.
// req_i.ready rises again as soon as the result moves to the output
// register, so the next request is taken while rsp_o waits on a stall.
// reset empties every slot, clears the count, rewinds the iterator and sets
// slots_in_use to 128; no clearing pass is needed.
module slot_table_engine_top #(
  parameter int SLOTS       = 128,
  parameter int HANDLE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ste_req_if.sink                      req_i,
  ste_rsp_if.source                    rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ste_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import ste_pkg::*;

  localparam int CntW = $clog2(SLOTS + 1);
  localparam int IdxW = $clog2(SLOTS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_XFER
  } state_e;

  state_e                 state_q, state_d;
  logic                   start_q, start_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             slots_q, slots_d;
  logic [CntW-1:0]        count_q, count_d;
  logic [CntW-1:0]        iter_q, iter_d;

  // request held for the whole wave
  logic [3:0]             func_q, func_d;
  logic [6:0]             idx_q, idx_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;

  // finished result, then the output register
  logic [31:0]            res_handle_q, res_handle_d;
  logic [6:0]             res_index_q, res_index_d;
  logic                   res_hit_q, res_hit_d;
  logic [31:0]            out_handle_q, out_handle_d;
  logic [6:0]             out_index_q, out_index_d;
  logic                   out_hit_q, out_hit_d;
  logic [7:0]             out_count_q, out_count_d;

  logic                   ch_valid, ch_found;
  logic [HANDLE_BITS-1:0] ch_handle;
  logic [IdxW-1:0]        ch_index;
  logic [CntW-1:0]        size;
  logic                   req_take, cfg_wr, out_free, old_nz, new_nz;

  // config port, single register
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[ADDR_W-1:2] == REG_SLOTS_IN_USE);
  assign prdata = (paddr[ADDR_W-1:2] == REG_SLOTS_IN_USE) ? {24'd0, slots_q} : 32'd0;

  // size in use saturates at the table depth
  assign size = (32'(slots_q) > 32'(SLOTS)) ? CntW'(SLOTS) : CntW'(slots_q);

  assign req_i.ready = (state_q == S_IDLE);
  assign req_take    = req_i.valid & req_i.ready;
  assign out_free    = ~out_valid_q | rsp_o.ready;

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.result_handle = out_handle_q;
  assign rsp_o.result_index  = out_index_q;
  assign rsp_o.hit           = out_hit_q;
  assign rsp_o.item_count    = out_count_q;

  ste_chain #(
    .SLOTS      (SLOTS),
    .HANDLE_BITS(HANDLE_BITS)
  ) u_chain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .func_i      (func_q),
    .slot_index_i(idx_q),
    .handle_i    (handle_q),
    .size_i      (size),
    .iter_pos_i  (iter_q),
    .res_valid_o (ch_valid),
    .res_found_o (ch_found),
    .res_handle_o(ch_handle),
    .res_index_o (ch_index)
  );

  // occupancy change for write and clear: old handle against new one
  assign old_nz = |ch_handle;
  assign new_nz = (func_q == OP_WRITE) & (|handle_q);

  always_comb begin
    state_d      = state_q;
    start_d      = 1'b0;
    out_valid_d  = out_valid_q;
    slots_d      = slots_q;
    count_d      = count_q;
    iter_d       = iter_q;
    func_d       = func_q;
    idx_d        = idx_q;
    handle_d     = handle_q;
    res_handle_d = res_handle_q;
    res_index_d  = res_index_q;
    res_hit_d    = res_hit_q;
    out_handle_d = out_handle_q;
    out_index_d  = out_index_q;
    out_hit_d    = out_hit_q;
    out_count_d  = out_count_q;

    if (cfg_wr) begin
      slots_d = pwdata[7:0];
    end

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req_take) begin
          func_d   = req_i.func;
          idx_d    = req_i.slot_index;
          handle_d = HANDLE_BITS'(req_i.handle);
          start_d  = 1'b1;
          state_d  = S_RUN;
        end
      end
      S_RUN: begin
        if (ch_valid) begin
          res_handle_d = 32'(ch_handle);
          res_index_d  = 7'(ch_index);
          res_hit_d    = ch_found;
          case (func_q)
            OP_READ: begin
            end
            OP_WRITE, OP_CLEAR: begin
              if (ch_found && old_nz && !new_nz) begin
                count_d = count_q - CntW'(1);
              end else if (ch_found && !old_nz && new_nz) begin
                count_d = count_q + CntW'(1);
              end
            end
            OP_REMOVE, OP_POP: begin
              if (ch_found) begin
                count_d = count_q - CntW'(1);
              end
            end
            OP_PUT: begin
              res_handle_d = 32'd0;
              if (ch_found) begin
                count_d = count_q + CntW'(1);
              end
            end
            OP_COUNT: begin
              res_hit_d = 1'b1;
            end
            OP_ITER_RESET: begin
              res_hit_d = 1'b1;
              iter_d    = '0;
            end
            OP_ITER_NEXT: begin
              if (ch_found) begin
                iter_d = CntW'(ch_index) + CntW'(1);
              end else if (iter_q < size) begin
                iter_d = size;
              end
            end
            default: begin
              res_hit_d = 1'b0;
            end
          endcase
          state_d = S_XFER;
        end
      end
      S_XFER: begin
        if (out_free) begin
          out_handle_d = res_handle_q;
          out_index_d  = res_index_q;
          out_hit_d    = res_hit_q;
          out_count_d  = 8'(count_q);
          out_valid_d  = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
      slots_q     <= SLOTS_IN_USE_RESET;
      count_q     <= '0;
      iter_q      <= '0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
      slots_q     <= slots_d;
      count_q     <= count_d;
      iter_q      <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q       <= func_d;
    idx_q        <= idx_d;
    handle_q     <= handle_d;
    res_handle_q <= res_handle_d;
    res_index_q  <= res_index_d;
    res_hit_q    <= res_hit_d;
    out_handle_q <= out_handle_d;
    out_index_q  <= out_index_d;
    out_hit_q    <= out_hit_d;
    out_count_q  <= out_count_d;
  end

endmodule

// ===== sim/slot_table_engine_checker.sv =====
module slot_table_engine_checker
  import ste_pkg::*;
#(
  parameter int SLOTS = 128
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ste_req_if                req_mon,
  ste_rsp_if                rsp_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int                error_count,
  output int                outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] SlotsInUseAddr = ADDR_W'({REG_SLOTS_IN_USE, 2'b00});

  typedef struct packed {
    logic [31:0] handle;
    logic [6:0]  index;
    logic        hit;
    logic [7:0]  count;
  } table_result_t;

  logic [31:0]   slot_mem [SLOTS];
  logic [7:0]    occupancy;
  int            scan_pos;
  logic [7:0]    slots_cfg;
  table_result_t result_q [$];
  table_result_t got;
  table_result_t want;

  // applies one request to the shadow table and returns what the block should answer
  function automatic table_result_t apply_request(input logic [3:0] f, input logic [6:0] idx,
                                                  input logic [31:0] h);
    table_result_t res;
    int            span;
    int            i;
    logic [31:0]   prior;
    logic [31:0]   fresh;
    res = '0;
    span = (slots_cfg > SLOTS) ? SLOTS : int'(slots_cfg);
    case (f)
      OP_READ, OP_WRITE, OP_CLEAR: begin
        if (int'(idx) < span) begin
          prior = slot_mem[idx];
          res.hit = 1'b1;
          res.index = idx;
          res.handle = prior;
          if (f != OP_READ) begin
            fresh = (f == OP_WRITE) ? h : '0;
            if (prior != '0 && fresh == '0) occupancy--;
            else if (prior == '0 && fresh != '0) occupancy++;
            slot_mem[idx] = fresh;
          end
        end
      end
      OP_REMOVE: begin
        if (h != '0) begin
          for (i = 0; i < span; i++) begin
            if (slot_mem[i] == h) begin
              slot_mem[i] = '0;
              occupancy--;
              res.handle = h;
              res.index = 7'(i);
              res.hit = 1'b1;
              break;
            end
          end
        end
      end
      OP_PUT: begin
        if (h != '0) begin
          for (i = 0; i < span; i++) begin
            if (slot_mem[i] == '0) begin
              slot_mem[i] = h;
              occupancy++;
              res.index = 7'(i);
              res.hit = 1'b1;
              break;
            end
          end
        end
      end
      OP_POP: begin
        for (i = 0; i < span; i++) begin
          if (slot_mem[i] != '0) begin
            res.handle = slot_mem[i];
            slot_mem[i] = '0;
            occupancy--;
            res.index = 7'(i);
            res.hit = 1'b1;
            break;
          end
        end
      end
      OP_COUNT: res.hit = 1'b1;
      OP_ITER_RESET: begin
        scan_pos = 0;
        res.hit = 1'b1;
      end
      OP_ITER_NEXT: begin
        for (i = scan_pos; i < span; i++) begin
          if (slot_mem[i] != '0) begin
            res.handle = slot_mem[i];
            res.index = 7'(i);
            res.hit = 1'b1;
            break;
          end
        end
        // exhausted iterator parks at the end of the range in use
        if (res.hit) scan_pos = int'(res.index) + 1;
        else if (scan_pos < span) scan_pos = span;
      end
      default: ;
    endcase
    res.count = occupancy;
    return res;
  endfunction

  initial begin
    error_count = 0;
    outstanding = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (slot_mem[k]) slot_mem[k] = '0;
      occupancy = '0;
      scan_pos = 0;
      slots_cfg = SLOTS_IN_USE_RESET;
      result_q.delete();
      outstanding = 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        got = '{rsp_mon.result_handle, rsp_mon.result_index, rsp_mon.hit, rsp_mon.item_count};
        if (result_q.size() == 0) begin
          $error("result with nothing outstanding: handle %h index %0d hit %b count %0d",
                 got.handle, got.index, got.hit, got.count);
          error_count++;
        end else begin
          want = result_q.pop_front();
          if (got.handle !== want.handle) begin
            $error("result_handle: expected %h, got %h", want.handle, got.handle);
            error_count++;
          end
          if (got.index !== want.index) begin
            $error("result_index: expected %0d, got %0d", want.index, got.index);
            error_count++;
          end
          if (got.hit !== want.hit) begin
            $error("hit: expected %b, got %b", want.hit, got.hit);
            error_count++;
          end
          if (got.count !== want.count) begin
            $error("item_count: expected %0d, got %0d", want.count, got.count);
            error_count++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready)
        result_q.push_back(apply_request(req_mon.func, req_mon.slot_index, req_mon.handle));
      if (psel && penable && pwrite && pready && paddr == SlotsInUseAddr)
        slots_cfg = pwdata[7:0];
      outstanding = result_q.size();
    end
  end

endmodule

// ===== sim/tb_slot_table_engine_top.sv =====
module tb_slot_table_engine_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ste_pkg::*;

  // slots_in_use lives at byte address 4 * register index
  localparam logic [ADDR_W-1:0] SlotsInUseAddr = ADDR_W'({REG_SLOTS_IN_USE, 2'b00});
  // func codes past the last operation do nothing
  localparam logic [3:0] FuncUnusedLow  = 4'(OP_ITER_NEXT) + 4'd1;
  localparam logic [3:0] FuncUnusedHigh = 4'hF;
  localparam int         PhaseCount = 8;
  localparam int         PhaseItems = 60;
  // table sizes per random phase: full, small, single, saturating, tiny, small, empty range, half
  localparam logic [7:0] PhaseSizes [PhaseCount] =
    '{8'd128, 8'd8, 8'd1, 8'd255, 8'd3, 8'd16, 8'd0, 8'd64};

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  int          fail_count;
  int          pending_results;
  int          tx_idle_pct;
  int          rx_stall_pct;
  logic [7:0]  cur_size;
  logic [31:0] handle_pool [8];

  ste_req_if req_ch ();
  ste_rsp_if rsp_ch ();

  slot_table_engine_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_ch),
    .rsp_o   (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // watches both channels and the register port, predicts every result
  slot_table_engine_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_ch),
    .rsp_mon     (rsp_ch),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .pready      (pready),
    .error_count (fail_count),
    .outstanding (pending_results)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("tb_slot_table_engine_top: errors");
    $finish;
  end

  // result side: stall at random with the current stall rate
  always @(negedge clk_i) begin
    rsp_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // issues one request; entered and left at a falling edge, valid stays high after
  // acceptance so back-to-back requests never drop valid within a time step
  task automatic send_request(input logic [3:0] f, input logic [6:0] idx,
                              input logic [31:0] h);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.func       <= f;
    req_ch.slot_index <= idx;
    req_ch.handle     <= h;
    do @(posedge clk_i); while (!req_ch.ready);
    @(negedge clk_i);
  endtask

  // drop valid and wait until every outstanding result has come back
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_results != 0) @(negedge clk_i);
    // block is idle once its last result is taken, the wait below is extra margin anyway
    repeat (4) @(negedge clk_i);
  endtask

  // register write only while idle: setup cycle then access cycle
  task automatic write_slots_in_use(input logic [7:0] value);
    settle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= SlotsInUseAddr;
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_size = value;
  endtask

  // mostly well-formed table traffic over a small handle pool so removes find their
  // targets and small tables fill up; out-of-range slots, zero handles and unused
  // func codes make up the noise
  task automatic random_request();
    int          roll;
    int          reach;
    logic [3:0]  f;
    logic [6:0]  idx;
    logic [31:0] h;
    roll = $urandom_range(0, 99);
    if (roll < 24) f = OP_PUT;
    else if (roll < 38) f = OP_REMOVE;
    else if (roll < 48) f = OP_POP;
    else if (roll < 58) f = OP_WRITE;
    else if (roll < 64) f = OP_CLEAR;
    else if (roll < 74) f = OP_READ;
    else if (roll < 78) f = OP_COUNT;
    else if (roll < 83) f = OP_ITER_RESET;
    else if (roll < 95) f = OP_ITER_NEXT;
    else f = 4'($urandom_range(FuncUnusedLow, FuncUnusedHigh));
    // one step past the range in use so the boundary miss shows up often
    reach = (cur_size > 8'd127) ? 127 : int'(cur_size);
    if ($urandom_range(0, 3) == 0) idx = 7'($urandom_range(0, 127));
    else idx = 7'($urandom_range(0, reach));
    roll = $urandom_range(0, 99);
    if (roll < 8) h = '0;
    else if (roll < 60) h = handle_pool[$urandom_range(0, 7)];
    else h = $urandom;
    send_request(f, idx, h);
  endtask

  initial begin
    int p;
    int n;
    // every input known from time zero, reset held
    rst_ni            = 1'b0;
    req_ch.valid      = 1'b0;
    req_ch.func       = OP_READ;
    req_ch.slot_index = '0;
    req_ch.handle     = '0;
    rsp_ch.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    tx_idle_pct       = 0;
    rx_stall_pct      = 0;
    cur_size          = SLOTS_IN_USE_RESET;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset size of 128
    send_request(OP_COUNT, 7'd0, 32'h0);
    send_request(OP_WRITE, 7'd0, 32'hFFFF_FFFF);
    send_request(OP_WRITE, 7'd127, 32'h0000_0001);
    send_request(OP_READ, 7'd127, 32'h0);
    // write of a zero handle behaves as a clear
    send_request(OP_WRITE, 7'd5, 32'h0);
    send_request(OP_CLEAR, 7'd0, 32'h0);
    // put of a zero handle misses
    send_request(OP_PUT, 7'd0, 32'h0);
    send_request(OP_PUT, 7'd0, 32'hA5A5_A5A5);
    // remove of zero misses, remove of an absent handle misses
    send_request(OP_REMOVE, 7'd0, 32'h0);
    send_request(OP_REMOVE, 7'd0, 32'h1234_5678);
    send_request(OP_REMOVE, 7'd0, 32'hA5A5_A5A5);
    // iterator walks to the last slot, then runs dry
    send_request(OP_ITER_RESET, 7'd0, 32'h0);
    send_request(OP_ITER_NEXT, 7'd0, 32'h0);
    send_request(OP_ITER_NEXT, 7'd0, 32'h0);
    // pop the only entry, then pop an empty table
    send_request(OP_POP, 7'd0, 32'h0);
    send_request(OP_POP, 7'd0, 32'h0);
    // unused func codes
    send_request(FuncUnusedLow, 7'd3, 32'h5555_5555);
    send_request(FuncUnusedHigh, 7'd127, 32'hFFFF_FFFF);

    // zero size: nothing is in range
    write_slots_in_use(8'd0);
    send_request(OP_PUT, 7'd0, 32'h0000_0007);
    send_request(OP_READ, 7'd0, 32'h0);
    send_request(OP_ITER_NEXT, 7'd0, 32'h0);
    send_request(OP_POP, 7'd0, 32'h0);

    // two slots: fill, then a put into the full table misses
    write_slots_in_use(8'd2);
    send_request(OP_PUT, 7'd0, 32'h5A5A_5A5A);
    send_request(OP_PUT, 7'd0, 32'h5A5A_5A5A);
    send_request(OP_PUT, 7'd0, 32'h0000_0003);
    send_request(OP_WRITE, 7'd2, 32'h0000_0009);

    // random phases, each with its own size and one of four idle patterns
    for (p = 0; p < PhaseCount; p++) begin
      write_slots_in_use(PhaseSizes[p]);
      case (p % 4)
        0: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          tx_idle_pct  = 87;
          rx_stall_pct = 0;
        end
        2: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 87;
        end
        default: begin
          tx_idle_pct  = 26;
          rx_stall_pct = 26;
        end
      endcase
      foreach (handle_pool[k]) handle_pool[k] = $urandom;
      for (n = 0; n < PhaseItems; n++) begin
        // now and then hold off until the block has drained completely
        if ($urandom_range(0, 39) == 0) settle();
        random_request();
      end
    end

    // drain, then give a stray result time to show up
    settle();
    repeat (25) @(negedge clk_i);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb_slot_table_engine_top: clean");
    end else begin
      $display("tb_slot_table_engine_top: errors");
    end
    $finish;
  end

endmodule
